// ===== rtl/core/grs_pkg.sv =====
// Shared types and constants for the group reversing stream block.
package grs_pkg;

	localparam int MAX_GROUP_DEF = 16;
	localparam int GS_W = 5;
	localparam logic [GS_W-1:0] GS_RESET = 5'd1;
	localparam int PADDR_W = 3;
	localparam logic REG_GROUP_SIZE = 1'b0;

	typedef struct packed {
		logic signed [31:0] value;
		logic               list_end;
	} item_t;

	typedef struct packed {
		logic signed [31:0] value_out;
		logic               run_end;
		logic               list_done;
	} result_t;

	typedef struct packed {
		logic valid;
		logic run_end;
		logic list_done;
	} res_flags_t;

endpackage

// ===== rtl/core/grs_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module grs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/grs_cfg.sv =====
// APB-style configuration register holding the group size.
module grs_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [grs_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output logic [grs_pkg::GS_W-1:0]    group_size
);

	logic [grs_pkg::GS_W-1:0] group_size_q;
	logic                     sel_gs;

	assign pready = 1'b1;
	assign sel_gs = (paddr[grs_pkg::PADDR_W-1] == grs_pkg::REG_GROUP_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_size_q <= grs_pkg::GS_RESET;
		end else if (psel && penable && pwrite && pready && sel_gs) begin
			group_size_q <= pwdata[grs_pkg::GS_W-1:0];
		end
	end

	assign prdata     = sel_gs ? {{(32 - grs_pkg::GS_W){1'b0}}, group_size_q} : 32'd0;
	assign group_size = group_size_q;

endmodule

// ===== rtl/core/grs_ctrl.sv =====
// Fill and drain sequencer: writes items into the buffer and reads groups back out.
module grs_ctrl #(
	parameter int MAX_GROUP = grs_pkg::MAX_GROUP_DEF,
	localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [grs_pkg::GS_W-1:0] group_size,
	input  logic                     item_valid,
	input  logic                     item_list_end,
	output logic                     item_stall,
	input  logic                     result_stall,
	output grs_pkg::res_flags_t      flags,
	output logic                     ram_we,
	output logic [AW-1:0]            ram_waddr,
	output logic                     ram_re,
	output logic [AW-1:0]            ram_raddr
);

	localparam int CW = $clog2(MAX_GROUP + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_READ = 3'b010,
		ST_SHOW = 3'b100
	} state_t;

	state_t        state_q;
	logic [CW-1:0] fill_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] idx_q;
	logic          rev_q;
	logic          last_q;

	logic [CW-1:0] k_eff;
	logic [CW-1:0] n_new;
	logic [CW-1:0] rd_idx;
	logic [CW-1:0] rd_pos;
	logic          accept;
	logic          full;
	logic          final_res;

	always_comb begin
		if (group_size == '0) begin
			k_eff = CW'(1);
		end else if (32'(group_size) > MAX_GROUP) begin
			k_eff = CW'(MAX_GROUP);
		end else begin
			k_eff = CW'(group_size);
		end
	end

	assign n_new      = fill_q + CW'(1);
	assign full       = (n_new >= k_eff);
	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;
	assign final_res  = (idx_q == n_q - CW'(1));

	assign ram_we    = accept;
	assign ram_waddr = fill_q[AW-1:0];

	assign rd_idx    = (state_q == ST_READ) ? idx_q : idx_q + CW'(1);
	assign rd_pos    = rev_q ? (n_q - CW'(1) - rd_idx) : rd_idx;
	assign ram_raddr = rd_pos[AW-1:0];
	assign ram_re    = (state_q == ST_READ) ||
	                   ((state_q == ST_SHOW) && !result_stall && !final_res);

	assign flags.valid     = (state_q == ST_SHOW);
	assign flags.run_end   = final_res;
	assign flags.list_done = final_res && last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			n_q     <= '0;
			idx_q   <= '0;
			rev_q   <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (full || item_list_end) begin
							fill_q  <= '0;
							n_q     <= n_new;
							idx_q   <= '0;
							rev_q   <= full;
							last_q  <= item_list_end;
							state_q <= ST_READ;
						end else begin
							fill_q <= n_new;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_SHOW;
				end
				ST_SHOW: begin
					if (!result_stall) begin
						if (final_res) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + CW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/group_reverse_stream.sv =====
// Top level of the group reversing stream block.
// An item that completes no group is taken without a stall and gives no result.
// An item that closes a group of n values or ends the list stalls input for a buffer
// read, then n results at one per cycle unless result_stall holds them.
// The buffer RAM has one read port, which sets the drain rate; its contents are undefined.
// Reset clears the fill count, the sequencer and result_valid, and sets group size to 1.
module group_reverse_stream #(
	parameter int MAX_GROUP = grs_pkg::MAX_GROUP_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [grs_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  grs_pkg::item_t              item,
	output logic                        result_valid,
	input  logic                        result_stall,
	output grs_pkg::result_t            result
);

	localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

	logic [grs_pkg::GS_W-1:0] group_size;
	grs_pkg::res_flags_t      flags;
	logic                     ram_we;
	logic [AW-1:0]            ram_waddr;
	logic                     ram_re;
	logic [AW-1:0]            ram_raddr;
	logic [31:0]              ram_rdata;

	grs_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.group_size (group_size)
	);

	grs_ctrl #(
		.MAX_GROUP (MAX_GROUP)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.group_size    (group_size),
		.item_valid    (item_valid),
		.item_list_end (item.list_end),
		.item_stall    (item_stall),
		.result_stall  (result_stall),
		.flags         (flags),
		.ram_we        (ram_we),
		.ram_waddr     (ram_waddr),
		.ram_re        (ram_re),
		.ram_raddr     (ram_raddr)
	);

	grs_ram #(
		.WIDTH (32),
		.DEPTH (MAX_GROUP)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (item.value),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign result_valid     = flags.valid;
	assign result.value_out = ram_rdata;
	assign result.run_end   = flags.run_end;
	assign result.list_done = flags.list_done;

	// No input is taken while results of the previous one are still pending.
	a_no_accept_while_draining: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> item_stall)
		else $error("input accepted while results are pending");

	// The end of a list always marks the end of its run.
	a_list_done_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.list_done) |-> result.run_end)
		else $error("list end without run end");

	// An item that ends the list always causes a drain.
	a_list_end_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall && item.list_end) |=> item_stall)
		else $error("list end caused no results");

	// After the final result of a run is transferred, the output goes empty.
	a_run_end_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_stall && result.run_end) |=> !result_valid)
		else $error("result shown after the end of its run");

endmodule

// ===== tb/sv/tb_group_reverse_stream.sv =====
// Self-checking testbench for the group reversing stream block.
module tb_group_reverse_stream;

	localparam int LIMIT = 500000;
	localparam int SETTLE = grs_pkg::MAX_GROUP_DEF + 4;
	localparam int RAND_ITEMS = 45;
	localparam int AW = grs_pkg::PADDR_W;
	localparam logic [AW-1:0] ADDR_GROUP_SIZE = AW'(4 * grs_pkg::REG_GROUP_SIZE);
	localparam logic [AW-1:0] ADDR_UNMAPPED = AW'(4);

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t            kind;
		logic [AW-1:0]        addr;
		logic [31:0]          data;
		logic [4:0]           count;
		logic                 last;
		logic                 typed;
		grs_pkg::result_t     want;
	} dir_row_t;

	localparam dir_row_t DIR_TAB [0:22] = '{
		'{ROW_ITEM, ADDR_GROUP_SIZE, 32'h8000_0000, 5'd1, 1'b0, 1'b1,
			'{32'sh8000_0000, 1'b1, 1'b0}},
		'{ROW_ITEM, ADDR_GROUP_SIZE, 32'h7FFF_FFFF, 5'd1, 1'b1, 1'b1,
			'{32'sh7FFF_FFFF, 1'b1, 1'b1}},
		'{ROW_ITEM, ADDR_GROUP_SIZE, 32'h0000_0000, 5'd1, 1'b0, 1'b1,
			'{32'sh0000_0000, 1'b1, 1'b0}},
		'{ROW_ITEM, ADDR_GROUP_SIZE, 32'hFFFF_FFFF, 5'd1, 1'b1, 1'b1,
			'{32'shFFFF_FFFF, 1'b1, 1'b1}},
		'{ROW_CFG,  ADDR_GROUP_SIZE, 32'd3,         5'd0, 1'b0, 1'b0, '0},
		'{ROW_ITEM, ADDR_GROUP_SIZE, 32'd10,        5'd3, 1'b1, 1'b0, '0},
		'{ROW_ITEM, ADDR_GROUP_SIZE, 32'd20,        5'd2, 1'b1, 1'b0, '0},
		'{ROW_ITEM, ADDR_GROUP_SIZE, 32'd24,        5'd1, 1'b0, 1'b0, '0},
		'{ROW_CFG,  ADDR_UNMAPPED,   32'd7,         5'd0, 1'b0, 1'b0, '0},
		'{ROW_ITEM, ADDR_GROUP_SIZE, 32'd30,        5'd2, 1'b0, 1'b0, '0},
		'{ROW_CFG,  ADDR_GROUP_SIZE, 32'hFFFF_FFE0, 5'd0, 1'b0, 1'b0, '0},
		'{ROW_ITEM, ADDR_GROUP_SIZE, 32'h5555_AAAA, 5'd1, 1'b0, 1'b1,
			'{32'sh5555_AAAA, 1'b1, 1'b0}},
		'{ROW_CFG,  ADDR_GROUP_SIZE, 32'd8,         5'd0, 1'b0, 1'b0, '0},
		'{ROW_ITEM, ADDR_GROUP_SIZE, 32'd40,        5'd5, 1'b0, 1'b0, '0},
		'{ROW_CFG,  ADDR_GROUP_SIZE, 32'd2,         5'd0, 1'b0, 1'b0, '0},
		'{ROW_ITEM, ADDR_GROUP_SIZE, 32'd45,        5'd1, 1'b0, 1'b0, '0},
		'{ROW_CFG,  ADDR_GROUP_SIZE, 32'd31,        5'd0, 1'b0, 1'b0, '0},
		'{ROW_ITEM, ADDR_GROUP_SIZE, 32'h0000_1000, 5'd16, 1'b0, 1'b0, '0},
		'{ROW_CFG,  ADDR_GROUP_SIZE, 32'd16,        5'd0, 1'b0, 1'b0, '0},
		'{ROW_ITEM, ADDR_GROUP_SIZE, 32'hFFFF_FFF8, 5'd16, 1'b1, 1'b0, '0},
		'{ROW_ITEM, ADDR_GROUP_SIZE, 32'h0000_3000, 5'd5, 1'b1, 1'b0, '0},
		'{ROW_CFG,  ADDR_GROUP_SIZE, 32'd1,         5'd0, 1'b0, 1'b0, '0},
		'{ROW_ITEM, ADDR_GROUP_SIZE, 32'hAAAA_5555, 5'd1, 1'b1, 1'b1,
			'{32'shAAAA_5555, 1'b1, 1'b1}}
	};

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    psel = 1'b0;
	logic                    penable = 1'b0;
	logic                    pwrite = 1'b0;
	logic [AW-1:0]           paddr = '0;
	logic [31:0]             pwdata = '0;
	logic [31:0]             prdata;
	logic                    pready;
	logic                    item_valid = 1'b0;
	logic                    item_stall;
	grs_pkg::item_t          in_item = '0;
	logic                    result_valid;
	logic                    result_stall = 1'b0;
	grs_pkg::result_t        out_res;

	logic signed [31:0]      grp_mem [grs_pkg::MAX_GROUP_DEF];
	int                      held = 0;
	logic [grs_pkg::GS_W-1:0] grp_size_reg = grs_pkg::GS_RESET;
	grs_pkg::result_t        fresh [$];
	grs_pkg::result_t        pending [$];

	int unsigned        cycles = 0;
	int                 errors = 0;
	int                 n_items = 0;
	int                 n_lists = 0;
	int                 n_results = 0;
	int                 n_writes = 0;
	int                 stall_left = 0;
	bit                 no_gaps = 1'b0;

	group_reverse_stream u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (in_item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (out_res)
	);

	always #4 clk = ~clk;

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic int group_len();
		if (grp_size_reg == 0)
			return 1;
		if (grp_size_reg > grs_pkg::MAX_GROUP_DEF)
			return grs_pkg::MAX_GROUP_DEF;
		return int'(grp_size_reg);
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	task automatic reverse_groups(input grs_pkg::item_t it);
		int n;
		grs_pkg::result_t r;
		fresh.delete();
		if (held < grs_pkg::MAX_GROUP_DEF) begin
			grp_mem[held] = it.value;
			held++;
		end
		n = held;
		if (n >= group_len()) begin
			for (int i = 0; i < n; i++) begin
				r.value_out = grp_mem[n - 1 - i];
				r.run_end = (i == n - 1);
				r.list_done = (i == n - 1) && it.list_end;
				fresh.push_back(r);
			end
			held = 0;
		end else if (it.list_end) begin
			for (int i = 0; i < n; i++) begin
				r.value_out = grp_mem[i];
				r.run_end = (i == n - 1);
				r.list_done = (i == n - 1);
				fresh.push_back(r);
			end
			held = 0;
		end
	endtask

	task automatic send_item(input grs_pkg::item_t it, input bit typed,
		input grs_pkg::result_t want);
		int g;
		item_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (item_stall);
		n_items++;
		if (it.list_end)
			n_lists++;
		reverse_groups(it);
		if (typed)
			pending.push_back(want);
		else
			foreach (fresh[i]) pending.push_back(fresh[i]);
		g = gap_len();
		if (g > 0) begin
			item_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [AW-1:0] addr, input logic [31:0] data);
		item_valid <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		n_writes++;
		if (addr == ADDR_GROUP_SIZE)
			grp_size_reg = data[grs_pkg::GS_W-1:0];
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_GROUP_SIZE;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== 32'(grp_size_reg)) begin
			$display("%0t: group_size read back expected %h, got %h", $time,
				32'(grp_size_reg), prdata);
			errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, pending.size());
			$display("** group_reverse_stream: FAILED **");
			$finish;
		end
	end

	always @(posedge clk) begin
		grs_pkg::result_t want;
		int g;
		if (arst_n && result_valid && !result_stall) begin
			n_results++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %h", $time, out_res);
				errors++;
			end else begin
				want = pending.pop_front();
				if (out_res.value_out !== want.value_out) begin
					$display("%0t: value_out expected %h, got %h", $time,
						want.value_out, out_res.value_out);
					errors++;
				end
				if (out_res.run_end !== want.run_end) begin
					$display("%0t: run_end expected %b, got %b", $time,
						want.run_end, out_res.run_end);
					errors++;
				end
				if (out_res.list_done !== want.list_done) begin
					$display("%0t: list_done expected %b, got %b", $time,
						want.list_done, out_res.list_done);
					errors++;
				end
			end
		end
		if (stall_left > 0) begin
			result_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			g = gap_len();
			result_stall <= (g > 0);
			stall_left <= (g > 0) ? g - 1 : 0;
		end
	end

	initial begin
		grs_pkg::item_t it;
		int rand_sent;
		int lists;
		int len;
		int gs;
		bit cut;
		rand_sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIR_TAB[r]) begin
			if (DIR_TAB[r].kind == ROW_CFG) begin
				write_reg(DIR_TAB[r].addr, DIR_TAB[r].data);
			end else begin
				for (int i = 0; i < int'(DIR_TAB[r].count); i++) begin
					it.value = DIR_TAB[r].data + 32'(i);
					it.list_end = DIR_TAB[r].last && (i == int'(DIR_TAB[r].count) - 1);
					send_item(it, DIR_TAB[r].typed, DIR_TAB[r].want);
				end
			end
		end

		while (rand_sent < RAND_ITEMS) begin
			case ($urandom_range(0, 9)) inside
				[0:4]: gs = $urandom_range(1, 4);
				[5:7]: gs = $urandom_range(5, 15);
				default: begin
					case ($urandom_range(0, 3))
						0: gs = 0;
						1: gs = 16;
						2: gs = 17;
						default: gs = 31;
					endcase
				end
			endcase
			write_reg(ADDR_GROUP_SIZE, ($urandom() & 32'hFFFF_FFE0) | 32'(gs));
			if ($urandom_range(0, 5) == 0)
				write_reg(ADDR_UNMAPPED, $urandom());
			no_gaps = ($urandom_range(0, 3) == 0);
			lists = $urandom_range(1, 3);
			for (int l = 0; l < lists && rand_sent < RAND_ITEMS; l++) begin
				len = $urandom_range(1, 2 * group_len() + 1);
				if (len > RAND_ITEMS - rand_sent)
					len = RAND_ITEMS - rand_sent;
				cut = (l == lists - 1) && ($urandom_range(0, 4) == 0);
				for (int j = 0; j < len; j++) begin
					it.value = pick_value();
					it.list_end = (j == len - 1) && !cut;
					send_item(it, 1'b0, '0);
					rand_sent++;
				end
			end
		end

		item_valid <= 1'b0;
		no_gaps = 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (SETTLE + 10) @(posedge clk);
		$display("Run covered %0d items in %0d complete lists, %0d results checked,",
			n_items, n_lists, n_results);
		$display("and %0d register writes across group sizes from zero to saturation.",
			n_writes);
		if (errors == 0)
			$display("** group_reverse_stream: PASSED **");
		else
			$display("** group_reverse_stream: FAILED **");
		$finish;
	end

endmodule
